// ===== sv/composite_key_max_heap_queue_macros.svh =====
// ----------------------------------------------------------------------------
// composite key max-heap queue assertion macros
// shared concurrent property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef COMPOSITE_KEY_MAX_HEAP_QUEUE_MACROS_SVH
`define COMPOSITE_KEY_MAX_HEAP_QUEUE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CKHQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ckhq checker: same-cycle property failed");

// next-cycle implication, disabled while in reset
`define CKHQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ckhq checker: next-cycle property failed");

`endif

// ===== sv/ckhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckhq_pkg
// types, codes and the priority compare of the composite key heap queue
// ----------------------------------------------------------------------------
package ckhq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int COUNT_W  = 7;
    localparam int DELAY_W  = 16;
    localparam int ID_W     = 16;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic               mandatory;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    entry_id;
    } entry_t;

    // a ranks strictly above b: mandatory, then delay, then lower id
    function automatic logic outranks(input entry_t a, input entry_t b);
        logic [DELAY_W+ID_W:0] key_a;
        logic [DELAY_W+ID_W:0] key_b;
        key_a = {a.mandatory, a.delay, ~a.entry_id};
        key_b = {b.mandatory, b.delay, ~b.entry_id};
        return key_a > key_b;
    endfunction

endpackage

// ===== sv/composite_key_max_heap_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// composite_key_max_heap_queue
// binary max-heap priority queue with one result word per command word
// ----------------------------------------------------------------------------
// insert: into an empty queue the entry goes straight to the root, else it climbs one parent compare at a time
// extract: the last entry alone just empties the queue, else it is loaded and sifted down level by level
// the sequencing is set by the single heap memory port and the one shared compare
// one word in flight at a time; s_ready high only while idle
// reset (synchronous, aresetn low) empties the queue and drops any result
// heap memory content is not cleared; slots at or past the count are never used

module composite_key_max_heap_queue (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic                          s_mandatory,
    input  logic [ckhq_pkg::DELAY_W-1:0]  s_delay,
    input  logic [ckhq_pkg::ID_W-1:0]     s_entry_id,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_taken_mandatory,
    output logic [ckhq_pkg::DELAY_W-1:0]  m_taken_delay,
    output logic [ckhq_pkg::ID_W-1:0]     m_taken_id,
    output logic                          m_top_valid,
    output logic                          m_top_mandatory,
    output logic [ckhq_pkg::DELAY_W-1:0]  m_top_delay,
    output logic [ckhq_pkg::ID_W-1:0]     m_top_id,
    output logic [ckhq_pkg::COUNT_W-1:0]  m_entry_count
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;  // waiting for a command word
    localparam logic [3:0] S_UP_RD  = 4'd1;  // read parent of the hole
    localparam logic [3:0] S_UP_CMP = 4'd2;  // compare new entry with parent
    localparam logic [3:0] S_WR_E   = 4'd3;  // drop moving entry into the hole
    localparam logic [3:0] S_EX_LD  = 4'd4;  // last entry arrives from memory
    localparam logic [3:0] S_DN_RDL = 4'd5;  // read left child or finish
    localparam logic [3:0] S_DN_RDR = 4'd6;  // left child vs entry, read right
    localparam logic [3:0] S_DN_CMP = 4'd7;  // right child vs best so far
    localparam logic [3:0] S_RESP   = 4'd8;  // result word on offer

    logic [3:0]                    state_reg, state_next;
    logic [ckhq_pkg::ADDR_W-1:0]   pos_reg, pos_next;       // current hole
    logic [ckhq_pkg::CNT_W-1:0]    count_reg, count_next;
    ckhq_pkg::entry_t              entry_reg, entry_next;   // entry being sifted
    ckhq_pkg::entry_t              best_reg, best_next;     // winner of first compare
    logic                          best_left_reg, best_left_next;
    logic [1:0]                    status_reg, status_next;
    ckhq_pkg::entry_t              taken_reg, taken_next;
    ckhq_pkg::entry_t              top_reg;                 // mirror of slot zero

    // heap memory, one write and one registered read a cycle
    ckhq_pkg::entry_t              heap_mem [ckhq_pkg::CAPACITY];
    ckhq_pkg::entry_t              rd_data_reg;
    logic                          mem_we;
    logic [ckhq_pkg::ADDR_W-1:0]   mem_waddr;
    ckhq_pkg::entry_t              mem_wdata;
    logic [ckhq_pkg::ADDR_W-1:0]   mem_raddr;

    // shared compare unit
    ckhq_pkg::entry_t              cmp_a;
    ckhq_pkg::entry_t              cmp_b;
    logic                          cmp_win;

    // heap index arithmetic around the hole
    logic [ckhq_pkg::ADDR_W-1:0]   parent_idx;
    logic [ckhq_pkg::CHILD_W-1:0]  left_idx;
    logic [ckhq_pkg::CHILD_W-1:0]  right_idx;
    logic [ckhq_pkg::CHILD_W-1:0]  count_ext;
    logic                          has_left;
    logic                          has_right;

    ckhq_pkg::entry_t              in_entry;

    assign in_entry.mandatory = s_mandatory;
    assign in_entry.delay     = s_delay;
    assign in_entry.entry_id  = s_entry_id;

    assign parent_idx = ckhq_pkg::ADDR_W'((pos_reg - ckhq_pkg::ADDR_W'(1)) >> 1);
    assign left_idx   = ckhq_pkg::CHILD_W'({pos_reg, 1'b1});
    assign right_idx  = left_idx + ckhq_pkg::CHILD_W'(1);
    assign count_ext  = ckhq_pkg::CHILD_W'(count_reg);
    assign has_left   = left_idx < count_ext;
    assign has_right  = right_idx < count_ext;

    // operand selection for the single comparator
    always_comb begin
        unique case (state_reg)
            S_UP_CMP: begin
                cmp_a = entry_reg;
                cmp_b = rd_data_reg;
            end
            S_DN_CMP: begin
                cmp_a = rd_data_reg;
                cmp_b = best_reg;
            end
            default: begin
                cmp_a = rd_data_reg;
                cmp_b = entry_reg;
            end
        endcase
    end

    assign cmp_win = ckhq_pkg::outranks(cmp_a, cmp_b);

    // read address follows the state that consumes the registered data in the next cycle
    always_comb begin
        unique case (state_reg)
            S_IDLE:   mem_raddr = ckhq_pkg::ADDR_W'(count_reg - ckhq_pkg::CNT_W'(1));
            S_UP_RD:  mem_raddr = parent_idx;
            S_DN_RDL: mem_raddr = ckhq_pkg::ADDR_W'(left_idx);
            S_DN_RDR: mem_raddr = ckhq_pkg::ADDR_W'(right_idx);
            default:  mem_raddr = pos_reg;
        endcase
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        entry_next     = entry_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        status_next    = status_reg;
        taken_next     = taken_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = entry_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    taken_next  = '0;
                    status_next = ckhq_pkg::STATUS_OK;
                    if (s_command == ckhq_pkg::CMD_INSERT) begin
                        if (count_reg >= ckhq_pkg::CNT_W'(ckhq_pkg::CAPACITY)) begin
                            status_next = ckhq_pkg::STATUS_OVERFLOW;
                            state_next  = S_RESP;
                        end else begin
                            entry_next = in_entry;
                            pos_next   = ckhq_pkg::ADDR_W'(count_reg);
                            count_next = count_reg + ckhq_pkg::CNT_W'(1);
                            // root slot needs no climb
                            state_next = (count_reg == '0) ? S_WR_E : S_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ckhq_pkg::STATUS_UNDERFLOW;
                            state_next  = S_RESP;
                        end else begin
                            taken_next = top_reg;
                            count_next = count_reg - ckhq_pkg::CNT_W'(1);
                            pos_next   = '0;
                            // last entry is being read this cycle
                            state_next = (count_reg == ckhq_pkg::CNT_W'(1)) ? S_RESP
                                                                              : S_EX_LD;
                        end
                    end
                end
            end

            S_UP_RD: begin
                state_next = S_UP_CMP;
            end

            S_UP_CMP: begin
                mem_we = 1'b1;
                if (cmp_win) begin
                    // parent moves down into the hole
                    mem_wdata  = rd_data_reg;
                    pos_next   = parent_idx;
                    state_next = (parent_idx == '0) ? S_WR_E : S_UP_RD;
                end else begin
                    state_next = S_RESP;
                end
            end

            S_WR_E: begin
                mem_we     = 1'b1;
                state_next = S_RESP;
            end

            S_EX_LD: begin
                entry_next = rd_data_reg;
                state_next = S_DN_RDL;
            end

            S_DN_RDL: begin
                if (has_left) begin
                    state_next = S_DN_RDR;
                end else begin
                    mem_we     = 1'b1;
                    state_next = S_RESP;
                end
            end

            S_DN_RDR: begin
                best_left_next = cmp_win;
                best_next      = cmp_win ? rd_data_reg : entry_reg;
                if (has_right) begin
                    state_next = S_DN_CMP;
                end else begin
                    // only a left child: decide here
                    mem_we = 1'b1;
                    if (cmp_win) begin
                        mem_wdata  = rd_data_reg;
                        pos_next   = ckhq_pkg::ADDR_W'(left_idx);
                        state_next = S_DN_RDL;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end

            S_DN_CMP: begin
                mem_we = 1'b1;
                if (cmp_win) begin
                    mem_wdata  = rd_data_reg;
                    pos_next   = ckhq_pkg::ADDR_W'(right_idx);
                    state_next = S_DN_RDL;
                end else if (best_left_reg) begin
                    mem_wdata  = best_reg;
                    pos_next   = ckhq_pkg::ADDR_W'(left_idx);
                    state_next = S_DN_RDL;
                end else begin
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        entry_reg     <= entry_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        status_reg    <= status_next;
        taken_reg     <= taken_next;
        if (mem_we && (mem_waddr == '0)) begin
            top_reg <= mem_wdata;
        end
    end

    // heap memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= heap_mem[mem_raddr];
    end

    // handshakes
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);

    // result word
    assign m_status          = status_reg;
    assign m_taken_mandatory = taken_reg.mandatory;
    assign m_taken_delay     = taken_reg.delay;
    assign m_taken_id        = taken_reg.entry_id;
    assign m_top_valid       = (count_reg != '0);
    assign m_top_mandatory   = m_top_valid ? top_reg.mandatory : 1'b0;
    assign m_top_delay       = m_top_valid ? top_reg.delay     : '0;
    assign m_top_id          = m_top_valid ? top_reg.entry_id  : '0;
    assign m_entry_count     = ckhq_pkg::COUNT_W'(count_reg);

endmodule

// ===== sv/ckhq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckhq_checker
// port-level checks of the composite key heap queue, bound to the top level
// ----------------------------------------------------------------------------
`include "composite_key_max_heap_queue_macros.svh"

module ckhq_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_status,
    input  logic                          m_top_valid,
    input  logic [ckhq_pkg::COUNT_W-1:0]  m_entry_count
);

    logic accept_in;

    assign accept_in = s_valid && s_ready;

    // one word in flight: no new word while a result waits
    `CKHQ_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

    // accepting a word closes the input side in the next cycle
    `CKHQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept_in, !s_ready)

    // top entry present exactly when the queue is not empty
    `CKHQ_ASSERT_IMPL(a_top_matches_count, aclk, aresetn, m_valid,
                      m_top_valid == (m_entry_count != '0))

    // underflow only on an empty queue, overflow only on a full one
    `CKHQ_ASSERT_IMPL(a_status_vs_count, aclk, aresetn,
                      m_valid && (m_status != ckhq_pkg::STATUS_OK),
                      ((m_status == ckhq_pkg::STATUS_UNDERFLOW) && (m_entry_count == '0))
                      || ((m_status == ckhq_pkg::STATUS_OVERFLOW)
                          && (m_entry_count == ckhq_pkg::COUNT_W'(ckhq_pkg::CAPACITY))))

endmodule

bind composite_key_max_heap_queue ckhq_checker u_ckhq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_top_valid   (m_top_valid),
    .m_entry_count (m_entry_count)
);
